// ===== src/sli_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types for the sorted list core: request kinds, result status codes,
// controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_DUMP   = 2'd2
  } mode_t;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DELETED   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_ELEMENT   = 3'd4,
    STAT_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_APPLY,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    compare;
    logic    do_insert;
    logic    do_delete;
    logic    rotate;
    logic    clr_idx;
    logic    emit;
    logic    emit_elem;
    status_t emit_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic found;
    logic dump_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/sli_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sli_datapath
// Row of compare-and-shift cells holding the sorted values, the entry count,
// the latched request, the registered less-than vector and match flag and the result register.
// ----------------------------------------------------------------------------
module sli_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sli_pkg::cmd_t                       cmd,
  input  wire logic signed [sli_pkg::ValueW-1:0]   req_in,
  output sli_pkg::dp_status_t                      stat,
  output logic             [sli_pkg::StatusW-1:0]  out_status,
  output logic signed      [sli_pkg::ValueW-1:0]   out_value,
  output logic                                     out_last
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [sli_pkg::ValueW-1:0] cells      [DEPTH];
  logic signed [sli_pkg::ValueW-1:0] cells_next [DEPTH];
  logic signed [sli_pkg::ValueW-1:0] req_value;
  logic        [CW-1:0]              count;
  logic        [CW-1:0]              idx;
  logic        [DEPTH-1:0]           lt;
  logic        [DEPTH-1:0]           lt_next;
  logic        [DEPTH-1:0]           eq_next;
  logic                              found;

  // parallel compare against every live cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt_next[i] = (CW'(i) < count) && (cells[i] < req_value);
      eq_next[i] = (CW'(i) < count) && (cells[i] == req_value);
    end
  end

  // per-cell next value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_next[i] = cells[i];
      if (cmd.do_insert) begin
        if (!lt[i]) begin
          if (i == 0) begin
            cells_next[i] = req_value;
          end else if (lt[(i == 0) ? 0 : i-1]) begin
            cells_next[i] = req_value;
          end else begin
            cells_next[i] = cells[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd.do_delete) begin
        if (!lt[i] && (i < DEPTH-1)) begin
          cells_next[i] = cells[(i < DEPTH-1) ? i+1 : i];
        end
      end else if (cmd.rotate) begin
        if (CW'(i + 1) < count) begin
          cells_next[i] = cells[(i < DEPTH-1) ? i+1 : i];
        end else if (CW'(i + 1) == count) begin
          cells_next[i] = cells[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells[i] <= cells_next[i];
    end
    if (cmd.load_req) begin
      req_value <= req_in;
    end
    if (cmd.compare) begin
      lt    <= lt_next;
      found <= |eq_next;
    end
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_value  <= cmd.emit_elem ? cells[0] : req_value;
      out_last   <= cmd.emit_elem ? stat.dump_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.do_insert) begin
        count <= count + CW'(1);
      end else if (cmd.do_delete) begin
        count <= count - CW'(1);
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.rotate) begin
        idx <= idx + CW'(1);
      end
    end
  end

  assign stat.full      = (count == CW'(DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.found     = found;
  assign stat.dump_last = (idx == (count - CW'(1)));

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.do_delete |=> count == $past(count) - CW'(1))
    else $error("delete did not shrink the list");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |-> !stat.full)
    else $error("insert into a full list");

  a_delete_needs_match: assert property (@(posedge clk) disable iff (rst)
    cmd.do_delete |-> (found && !stat.empty))
    else $error("delete without a match");

endmodule
`default_nettype wire

// ===== src/sli_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sli_ctrl
// Request sequencer: accepts a request, runs compare then apply, walks the
// list on a dump and owns the result valid flag.
// ----------------------------------------------------------------------------
module sli_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [sli_pkg::ModeW-1:0]         in_mode,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  input  wire sli_pkg::dp_status_t               stat,
  output sli_pkg::cmd_t                          cmd
);

  sli_pkg::state_t state;
  sli_pkg::state_t state_next;
  sli_pkg::mode_t  req_mode;
  logic            slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_mode <= sli_pkg::mode_t'(in_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.emit_status = sli_pkg::STAT_INSERTED;
    unique case (state)
      sli_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
        if (in_valid) begin
          unique case (in_mode)
            sli_pkg::MODE_INSERT,
            sli_pkg::MODE_DELETE,
            sli_pkg::MODE_DUMP: state_next = sli_pkg::ST_COMPARE;
            default:            state_next = sli_pkg::ST_IDLE;
          endcase
        end
      end
      sli_pkg::ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = sli_pkg::ST_APPLY;
      end
      sli_pkg::ST_APPLY: begin
        if (slot_free) begin
          state_next = sli_pkg::ST_IDLE;
          unique case (req_mode)
            sli_pkg::MODE_INSERT: begin
              cmd.emit        = 1'b1;
              cmd.do_insert   = !stat.full;
              cmd.emit_status = stat.full ? sli_pkg::STAT_FULL : sli_pkg::STAT_INSERTED;
            end
            sli_pkg::MODE_DELETE: begin
              cmd.emit        = 1'b1;
              cmd.do_delete   = stat.found;
              cmd.emit_status = stat.found ? sli_pkg::STAT_DELETED
                                           : sli_pkg::STAT_NOT_FOUND;
            end
            default: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = sli_pkg::STAT_EMPTY;
              end else begin
                cmd.clr_idx = 1'b1;
                state_next  = sli_pkg::ST_DUMP;
              end
            end
          endcase
        end
      end
      sli_pkg::ST_DUMP: begin
        if (slot_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_elem   = 1'b1;
          cmd.emit_status = sli_pkg::STAT_ELEMENT;
          cmd.rotate      = 1'b1;
          if (stat.dump_last) begin
            state_next = sli_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = sli_pkg::ST_IDLE;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == sli_pkg::ST_IDLE)
    else $error("request taken while busy");

  a_compare_then_apply: assert property (@(posedge clk) disable iff (rst)
    state == sli_pkg::ST_COMPARE |=> state == sli_pkg::ST_APPLY)
    else $error("compare not followed by apply");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> slot_free)
    else $error("result overwritten before it was taken");

  a_single_update: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.do_insert, cmd.do_delete, cmd.rotate}) <= 1)
    else $error("conflicting list updates");

endmodule
`default_nettype wire

// ===== src/sorted_list_insert_delete_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_core
// Bounded ascending list of signed 32-bit values with insert, delete and dump.
// ----------------------------------------------------------------------------
// One request is handled at a time. Insert and delete pass through accept,
// parallel compare across all cells and the apply step that shifts the cells
// and loads the result, and the next request is accepted in the cycle after
// the result is loaded. A dump passes accept, compare and apply, then the
// cell row rotates by one entry per cycle unless a result is stalled; the head
// cell feeds the result register. Results wait in an output register; a
// stalled result holds the sequencer in its apply or dump step. Unused
// request kinds are accepted and dropped with no result.
module sorted_list_insert_delete_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] item_value
  output logic [2:0]       m_axis_tuser,   // [2:0] status
  output logic             m_axis_tlast
);

  sli_pkg::cmd_t                     cmd;
  sli_pkg::dp_status_t               stat;
  logic signed [sli_pkg::ValueW-1:0] out_value;

  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sli_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_in     (s_axis_tdata),
    .stat       (stat),
    .out_status (m_axis_tuser),
    .out_value  (out_value),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = out_value;

endmodule
`default_nettype wire
